// File: hdl/cwts_pkg.sv
package cwts_pkg;

  localparam int unsigned NumStages = 8;
  localparam int unsigned SinW = 18;

  localparam logic [17:0] AngFull = 18'd46080;
  localparam logic [17:0] AngQuarter = 18'd11520;
  localparam logic [17:0] AngHalf = 18'd23040;
  localparam logic [17:0] AngThreeQ = 18'd34560;
  localparam logic [17:0] RadPerUnitQ30 = 18'd146409;
  localparam logic [30:0] Q30One = 31'd1073741824;
  localparam logic [16:0] SinOne = 17'd65536;

  // Reciprocals for the Taylor divisors after a power-of-two prescale:
  // 72 = 8 * 9, 42 = 2 * 21, 20 = 4 * 5 and 6 = 2 * 3.
  localparam logic [29:0] RecipNine = 30'd954437177;
  localparam logic [29:0] RecipTwentyOne = 30'd818089009;
  localparam logic [29:0] RecipFive = 30'd214748365;
  localparam logic [29:0] RecipThree = 30'd715827883;

  typedef enum logic [2:0] {
    REG_OFFSET_X = 3'd0,
    REG_OFFSET_Y = 3'd1,
    REG_ZOOM_GAIN = 3'd2,
    REG_SPIN_ANGLE = 3'd3,
    REG_TILT_ANGLE = 3'd4,
    REG_SCREEN_WIDTH = 3'd5,
    REG_SCREEN_HEIGHT = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic signed [23:0] world_x;
    logic signed [23:0] world_y;
    logic signed [23:0] height_z;
  } cwts_in_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic clipped;
  } cwts_out_t;

endpackage

// File: hdl/cwts_slot.sv
module cwts_slot (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic up_valid_i,
  input  logic down_ready_i,
  output logic up_ready_o,
  output logic valid_o,
  output logic load_o
);

  logic valid_q, valid_d;

  assign up_ready_o = ~valid_q | down_ready_i;
  assign load_o = up_valid_i & up_ready_o;
  assign valid_o = valid_q;

  always_comb begin
    if (load_o) begin
      valid_d = 1'b1;
    end else if (down_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

endmodule

// File: hdl/cwts_sine.sv
module cwts_sine (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic signed [16:0] spin_i,
  input  logic signed [16:0] tilt_i,
  output logic busy_o,
  output logic signed [cwts_pkg::SinW-1:0] spin_cos_o,
  output logic signed [cwts_pkg::SinW-1:0] spin_sin_o,
  output logic signed [cwts_pkg::SinW-1:0] tilt_sin_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_MOD, ST_QUAD, ST_XMUL, ST_X2, ST_TMUL, ST_DIV, ST_FIN, ST_STORE
  } state_e;

  typedef enum logic [1:0] {
    SEL_SPIN_COS, SEL_SPIN_SIN, SEL_TILT_SIN
  } sel_e;

  state_e state_q;
  sel_e sel_q;
  logic [17:0] m_q;
  logic [13:0] rq_q;
  logic neg_q;
  logic [30:0] x_q;
  logic [31:0] x2_q;
  logic [30:0] t_q;
  logic [31:0] div_q;
  logic cnt_q;
  logic [1:0] term_q;
  logic [16:0] val_q;
  logic signed [cwts_pkg::SinW-1:0] cos_q, sin_q, tsin_q;

  logic signed [17:0] angle;
  logic [1:0] quad;
  logic [17:0] r_full, rq_full;
  logic [61:0] sq_prod, fin_prod;
  logic [62:0] t_prod;
  logic [30:0] div_n;
  logic [29:0] magic;
  logic [60:0] q_prod;
  logic [31:0] quot;
  logic [31:0] s_raw, s_rnd;
  logic [16:0] s_clamp;
  logic signed [cwts_pkg::SinW-1:0] res;

  always_comb begin
    case (sel_q)
      SEL_SPIN_COS: angle = 18'(spin_i) + $signed({1'b0, 17'(cwts_pkg::AngQuarter)});
      SEL_SPIN_SIN: angle = 18'(spin_i);
      default: angle = 18'(tilt_i);
    endcase
  end

  always_comb begin
    if (m_q < cwts_pkg::AngQuarter) begin
      quad = 2'd0;
      r_full = m_q;
    end else if (m_q < cwts_pkg::AngHalf) begin
      quad = 2'd1;
      r_full = m_q - cwts_pkg::AngQuarter;
    end else if (m_q < cwts_pkg::AngThreeQ) begin
      quad = 2'd2;
      r_full = m_q - cwts_pkg::AngHalf;
    end else begin
      quad = 2'd3;
      r_full = m_q - cwts_pkg::AngThreeQ;
    end
    rq_full = quad[0] ? (cwts_pkg::AngQuarter - r_full) : r_full;
  end

  assign sq_prod = 62'(x_q) * 62'(x_q);
  assign t_prod = 63'(x2_q) * 63'(t_q);
  assign fin_prod = 62'(x_q) * 62'(t_q);

  always_comb begin
    case (term_q)
      2'd0: begin
        div_n = {2'b0, div_q[31:3]};
        magic = cwts_pkg::RecipNine;
      end
      2'd1: begin
        div_n = div_q[31:1];
        magic = cwts_pkg::RecipTwentyOne;
      end
      2'd2: begin
        div_n = {1'b0, div_q[31:2]};
        magic = cwts_pkg::RecipFive;
      end
      default: begin
        div_n = div_q[31:1];
        magic = cwts_pkg::RecipThree;
      end
    endcase
  end

  assign q_prod = 61'(div_n) * 61'(magic);

  always_comb begin
    case (term_q)
      2'd0: quot = {4'b0, q_prod[60:33]};
      2'd1: quot = {5'b0, q_prod[60:34]};
      2'd2: quot = {1'b0, q_prod[60:30]};
      default: quot = {2'b0, q_prod[60:31]};
    endcase
  end

  assign s_raw = fin_prod[61:30];
  assign s_rnd = s_raw + 32'd8192;
  assign s_clamp = (s_rnd[31:14] > 18'(cwts_pkg::SinOne)) ? cwts_pkg::SinOne
                                                           : s_rnd[30:14];
  assign res = neg_q ? -$signed({1'b0, val_q}) : $signed({1'b0, val_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q <= SEL_SPIN_COS;
      cos_q <= $signed({1'b0, cwts_pkg::SinOne});
      sin_q <= '0;
      tsin_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            sel_q <= SEL_SPIN_COS;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          m_q <= 18'(19'(angle) + 19'sd92160);
          state_q <= ST_MOD;
        end
        ST_MOD: begin
          if (m_q >= cwts_pkg::AngFull) begin
            m_q <= m_q - cwts_pkg::AngFull;
          end else begin
            state_q <= ST_QUAD;
          end
        end
        ST_QUAD: begin
          rq_q <= 14'(rq_full);
          neg_q <= quad[1];
          if (rq_full == '0) begin
            val_q <= '0;
            state_q <= ST_STORE;
          end else if (rq_full >= cwts_pkg::AngQuarter) begin
            val_q <= cwts_pkg::SinOne;
            state_q <= ST_STORE;
          end else begin
            state_q <= ST_XMUL;
          end
        end
        ST_XMUL: begin
          x_q <= 31'(32'(rq_q) * 32'(cwts_pkg::RadPerUnitQ30));
          state_q <= ST_X2;
        end
        ST_X2: begin
          x2_q <= sq_prod[61:30];
          t_q <= cwts_pkg::Q30One;
          term_q <= 2'd0;
          state_q <= ST_TMUL;
        end
        ST_TMUL: begin
          div_q <= t_prod[61:30];
          cnt_q <= 1'b0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          div_q <= quot;
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!cnt_q && term_q != 2'd3) begin
            t_q <= cwts_pkg::Q30One - div_q[30:0];
            term_q <= term_q + 2'd1;
            state_q <= ST_TMUL;
          end else if (!cnt_q) begin
            t_q <= cwts_pkg::Q30One - div_q[30:0];
            cnt_q <= 1'b1;
          end else begin
            val_q <= s_clamp;
            state_q <= ST_STORE;
          end
        end
        ST_STORE: begin
          case (sel_q)
            SEL_SPIN_COS: begin
              cos_q <= res;
              sel_q <= SEL_SPIN_SIN;
              state_q <= ST_LOAD;
            end
            SEL_SPIN_SIN: begin
              sin_q <= res;
              sel_q <= SEL_TILT_SIN;
              state_q <= ST_LOAD;
            end
            default: begin
              tsin_q <= res;
              state_q <= ST_IDLE;
            end
          endcase
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o = state_q != ST_IDLE;
  assign spin_cos_o = cos_q;
  assign spin_sin_o = sin_q;
  assign tilt_sin_o = tsin_q;

endmodule

// File: hdl/camera_world_to_screen.sv
// Maps world points (x, y, height in Q16.8) to 16-bit screen pixels through
// offset, zoom, rotation and tilt.
// Points enter on the in channel and results leave on the out channel, both
// valid/ready. One transaction per cycle is sustained while the sine unit is
// idle and the receiver is ready. Each point passes through the eight
// pipeline cells, which each hold one point, on its way to the out channel.
// When the receiver stalls, results wait in their cells and the in channel
// keeps accepting until every cell is full, then ready drops.
// Registers are written on the cfg channel by index. A write of either angle
// starts the sine unit, which evaluates cosine and sine of the spin and sine
// of the tilt one after another, with the Taylor divisions done by reciprocal
// multiplication; while it runs, neither the in nor the cfg channel is ready.
// Reset empties the pipeline, sets the offsets, zoom and angles to zero and
// the screen to 800 by 600; no pass is needed after reset.
module camera_world_to_screen (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cwts_pkg::cwts_in_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cwts_pkg::cwts_out_t out_data_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  localparam int unsigned NS = cwts_pkg::NumStages;

  logic signed [23:0] off_x_q, off_y_q;
  logic signed [15:0] zoom_q;
  logic signed [16:0] spin_q, tilt_q;
  logic [12:0] scr_w_q, scr_h_q;

  logic busy, cfg_fire, trig_start;
  logic signed [cwts_pkg::SinW-1:0] cos_v, sin_v, tsin_v;

  logic [NS-1:0] up_v, dn_r, up_r, vld, ld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= '0;
      off_y_q <= '0;
      zoom_q <= '0;
      spin_q <= '0;
      tilt_q <= '0;
      scr_w_q <= 13'd800;
      scr_h_q <= 13'd600;
    end else if (cfg_fire) begin
      case (cfg_index_i)
        cwts_pkg::REG_OFFSET_X: off_x_q <= cfg_data_i;
        cwts_pkg::REG_OFFSET_Y: off_y_q <= cfg_data_i;
        cwts_pkg::REG_ZOOM_GAIN: zoom_q <= cfg_data_i[15:0];
        cwts_pkg::REG_SPIN_ANGLE: spin_q <= cfg_data_i[16:0];
        cwts_pkg::REG_TILT_ANGLE: tilt_q <= cfg_data_i[16:0];
        cwts_pkg::REG_SCREEN_WIDTH: scr_w_q <= cfg_data_i[12:0];
        cwts_pkg::REG_SCREEN_HEIGHT: scr_h_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = ~busy;
  assign cfg_fire = cfg_valid_i & cfg_ready_o;
  assign trig_start = cfg_fire & ((cfg_index_i == cwts_pkg::REG_SPIN_ANGLE) |
                                  (cfg_index_i == cwts_pkg::REG_TILT_ANGLE));

  cwts_sine u_sine (
    .clk_i,
    .rst_ni,
    .start_i(trig_start),
    .spin_i(spin_q),
    .tilt_i(tilt_q),
    .busy_o(busy),
    .spin_cos_o(cos_v),
    .spin_sin_o(sin_v),
    .tilt_sin_o(tsin_v)
  );

  for (genvar k = 0; k < NS; k++) begin : g_slot
    cwts_slot u_slot (
      .clk_i,
      .rst_ni,
      .up_valid_i(up_v[k]),
      .down_ready_i(dn_r[k]),
      .up_ready_o(up_r[k]),
      .valid_o(vld[k]),
      .load_o(ld[k])
    );
  end

  assign up_v = {vld[NS-2:0], in_valid_i & ~busy};
  assign dn_r = {out_ready_i, up_r[NS-1:1]};
  assign in_ready_o = up_r[0] & ~busy;
  assign out_valid_o = vld[NS-1];

  logic signed [21:0] cx, cy;
  assign cx = $signed({1'b0, scr_w_q, 8'b0} >> 1);
  assign cy = $signed({1'b0, scr_h_q, 8'b0} >> 1);

  logic signed [24:0] x0_q, y0_q;
  logic signed [23:0] hz0_q, hz1_q, hz2_q, hz3_q;
  logic signed [24:0] x1_q, y1_q;
  logic signed [41:0] zx1_q, zy1_q;
  logic signed [34:0] x2_q, y2_q;
  logic signed [53:0] pxc_q, pys_q, pxs_q, pyc_q;
  logic signed [39:0] xr4_q, yr4_q, xr5_q, yr5_q;
  logic signed [40:0] e4_q;
  logic signed [58:0] pt5_q;
  logic signed [43:0] x6_q, y6_q;

  logic signed [25:0] dx0, dy0;
  logic signed [35:0] dx2, dy2;
  logic signed [54:0] sum_x, sum_y;
  logic signed [38:0] rot_x, rot_y;
  logic signed [43:0] px_full, py_full;
  logic x_hi, x_lo, y_hi, y_lo;

  assign dx0 = 26'(x0_q) - 26'(cx);
  assign dy0 = 26'(y0_q) - 26'(cy);
  assign dx2 = 36'(x2_q) - 36'(cx);
  assign dy2 = 36'(y2_q) - 36'(cy);
  assign sum_x = 55'(pxc_q) - 55'(pys_q);
  assign sum_y = 55'(pxs_q) + 55'(pyc_q);
  assign rot_x = 39'(sum_x >>> 16);
  assign rot_y = 39'(sum_y >>> 16);
  assign px_full = x6_q / 44'sd256;
  assign py_full = y6_q / 44'sd256;
  assign x_hi = px_full > 44'sd32767;
  assign x_lo = px_full < -44'sd32768;
  assign y_hi = py_full > 44'sd32767;
  assign y_lo = py_full < -44'sd32768;

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      x0_q <= 25'(in_data_i.world_x) + 25'(off_x_q);
      y0_q <= 25'(in_data_i.world_y) + 25'(off_y_q);
      hz0_q <= in_data_i.height_z;
    end
    if (ld[1]) begin
      zx1_q <= 42'(dx0) * 42'(zoom_q);
      zy1_q <= 42'(dy0) * 42'(zoom_q);
      x1_q <= x0_q;
      y1_q <= y0_q;
      hz1_q <= hz0_q;
    end
    if (ld[2]) begin
      x2_q <= 35'(x1_q) + 35'(zx1_q >>> 8);
      y2_q <= 35'(y1_q) + 35'(zy1_q >>> 8);
      hz2_q <= hz1_q;
    end
    if (ld[3]) begin
      pxc_q <= 54'(dx2) * 54'(cos_v);
      pys_q <= 54'(dy2) * 54'(sin_v);
      pxs_q <= 54'(dx2) * 54'(sin_v);
      pyc_q <= 54'(dy2) * 54'(cos_v);
      hz3_q <= hz2_q;
    end
    if (ld[4]) begin
      xr4_q <= 40'(cx) + 40'(rot_x);
      yr4_q <= 40'(cy) + 40'(rot_y);
      e4_q <= 41'(rot_y) - 41'(hz3_q);
    end
    if (ld[5]) begin
      pt5_q <= 59'(e4_q) * 59'(tsin_v);
      xr5_q <= xr4_q;
      yr5_q <= yr4_q;
    end
    if (ld[6]) begin
      x6_q <= 44'(xr5_q);
      y6_q <= 44'(yr5_q) - 44'(pt5_q >>> 16);
    end
    if (ld[7]) begin
      out_data_o.screen_x <= x_hi ? 16'sh7fff : (x_lo ? 16'sh8000 : px_full[15:0]);
      out_data_o.screen_y <= y_hi ? 16'sh7fff : (y_lo ? 16'sh8000 : py_full[15:0]);
      out_data_o.clipped <= x_hi | x_lo | y_hi | y_lo;
    end
  end

endmodule
